// ===== src/ddtc_pkg.sv =====
// Package for the differential-drive turn controller.
// Holds beat structs, register map, reset values and control structs.
// No dependencies.
`timescale 1ns / 1ps

package ddtc_pkg;

	// Fixed field widths
	localparam int SAMPLE_BITS    = 12;
	localparam int COUNT_BITS     = 16;
	localparam int STEP_BITS_DFLT = 8;
	localparam int KICK_STEPS     = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] REG_LEFT_BASE     = 3'd0;
	localparam logic [2:0] REG_LEFT_GAIN     = 3'd1;
	localparam logic [2:0] REG_RIGHT_BASE    = 3'd2;
	localparam logic [2:0] REG_RIGHT_GAIN    = 3'd3;
	localparam logic [2:0] REG_TURN_SLOPE    = 3'd4;
	localparam logic [2:0] REG_STEADY_OFFSET = 3'd5;
	localparam logic [2:0] REG_JOLT_PWM      = 3'd6;
	localparam logic [2:0] REG_RUN_LENGTHS   = 3'd7;

	// Register reset values
	localparam logic [15:0] RST_LEFT_BASE     = 16'd33970;
	localparam logic [11:0] RST_LEFT_GAIN     = 12'd404;
	localparam logic [15:0] RST_RIGHT_BASE    = 16'd29443;
	localparam logic [11:0] RST_RIGHT_GAIN    = 12'd448;
	localparam logic [11:0] RST_TURN_SLOPE    = 12'd368;
	localparam logic [7:0]  RST_STEADY_OFFSET = 8'hFC;
	localparam logic [15:0] RST_JOLT_PWM      = 16'd51440;
	localparam logic [31:0] RST_RUN_LENGTHS   = 32'd840512070;

	// Route codes
	localparam logic [1:0] ROUTE_FAR   = 2'd0;
	localparam logic [1:0] ROUTE_LEFT  = 2'd1;
	localparam logic [1:0] ROUTE_CLOSE = 2'd2;
	localparam logic [1:0] ROUTE_RIGHT = 2'd3;

	typedef struct packed {
		logic                   action;
		logic [SAMPLE_BITS-1:0] left_sample;
		logic [SAMPLE_BITS-1:0] right_sample;
	} item_t;

	typedef struct packed {
		logic [7:0]            left_pwm;
		logic [7:0]            right_pwm;
		logic [1:0]            route;
		logic                  driving;
		logic [COUNT_BITS-1:0] left_count;
		logic [COUNT_BITS-1:0] right_count;
	} result_t;

	typedef struct packed {
		logic [15:0]       left_base;
		logic [11:0]       left_gain;
		logic [15:0]       right_base;
		logic [11:0]       right_gain;
		logic [11:0]       turn_slope;
		logic signed [7:0] steady_offset;
		logic [15:0]       jolt_pwm;
		logic [31:0]       run_lengths;
	} cfg_t;

	// Sequencer strobes to a wheel lane
	typedef struct packed {
		logic load;    // beat accepted: form weighted sum
		logic quot;    // reciprocal multiply
		logic commit;  // correct quotient, hysteresis, count
		logic clear;   // listen state: counts restart
	} lane_ctl_t;

	// Sequencer strobes to the merge/feedback stage
	typedef struct packed {
		logic load;  // beat accepted: latch action, ramp product
		logic diff;  // error term
		logic mult;  // gain products
		logic fin;   // clamp and update state
	} ctrl_ctl_t;

	// Next controller state, shown on the result beat
	typedef struct packed {
		logic [7:0] left_pwm;
		logic [7:0] right_pwm;
		logic [1:0] route;
		logic       driving;
	} ctrl_stat_t;

endpackage

// ===== src/ddtc_wheel.sv =====
// One wheel lane: smoothing filter with divide-by-ten, hysteresis, count.
// Depends on ddtc_pkg.
`timescale 1ns / 1ps

module ddtc_wheel import ddtc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lane_ctl_t              ctl,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [COUNT_BITS-1:0]  count
);

	// 3*avg + 7*sample stays below 16 * 2^SAMPLE_BITS
	localparam int SUM_W = SAMPLE_BITS + 4;
	localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / 64'd10);
	localparam logic [SAMPLE_BITS-1:0] THR_LO =
		SAMPLE_BITS'(((64'd1 << SAMPLE_BITS) * 64'd2) / 64'd10);
	localparam logic [SAMPLE_BITS-1:0] THR_HI =
		SAMPLE_BITS'(((64'd1 << SAMPLE_BITS) * 64'd8) / 64'd10);
	localparam logic [SUM_W-1:0] TEN = SUM_W'(10);

	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   level_q;
	logic [COUNT_BITS-1:0]  cnt_q;

	logic [SUM_W-1:0]       x_s1, x_s2;
	logic [SAMPLE_BITS-1:0] q_s2;

	logic [SUM_W-1:0]       avg_x, smp_x, q_x, x_d, rem;
	logic [2*SUM_W-1:0]     prod;
	logic [SAMPLE_BITS-1:0] avg_d;
	logic                   toggle;

	// Weighted sum: 3*avg as 2a+a, 7*s as 8s-s
	assign avg_x = SUM_W'(avg_q);
	assign smp_x = SUM_W'(sample);
	assign x_d   = (avg_x << 1) + avg_x + (smp_x << 3) - smp_x;

	// Quotient estimate, low by at most one
	assign prod = {{SUM_W{1'b0}}, x_s1} * {{SUM_W{1'b0}}, RECIP};

	// Remainder check fixes the estimate
	assign q_x   = SUM_W'(q_s2);
	assign rem   = x_s2 - ((q_x << 3) + (q_x << 1));
	assign avg_d = (rem >= TEN) ? q_s2 + SAMPLE_BITS'(1) : q_s2;

	assign toggle = (!level_q && (avg_d > THR_HI)) || (level_q && (avg_d < THR_LO));

	// Datapath stages
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_s1 <= x_d;
		end
		if (ctl.quot) begin
			x_s2 <= x_s1;
			q_s2 <= prod[SUM_W +: SAMPLE_BITS];
		end
	end

	// Filter, level and count state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			level_q <= 1'b0;
			cnt_q   <= '0;
		end else if (ctl.commit) begin
			avg_q <= avg_d;
			if (toggle) begin
				level_q <= !level_q;
			end
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (toggle) begin
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end
		end
	end

	assign count = cnt_q;

endmodule

// ===== src/ddtc_ctrl.sv =====
// Merge stage: combines both lane counts into the steering error, applies
// Q8 feedback, jolt and run-length sequencing. Depends on ddtc_pkg.
`timescale 1ns / 1ps

module ddtc_ctrl import ddtc_pkg::*; #(
	parameter int STEP_BITS = STEP_BITS_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_ctl_t             ctl,
	input  cfg_t                  cfg,
	input  logic                  action,
	input  logic [COUNT_BITS-1:0] left_count,
	input  logic [COUNT_BITS-1:0] right_count,
	output ctrl_stat_t            nxt,
	output logic                  listen
);

	localparam int DIFF_W = COUNT_BITS + 2;
	localparam int RAMP_W = 12 + STEP_BITS;
	localparam int DW     = ((DIFF_W + 8 > RAMP_W) ? DIFF_W + 8 : RAMP_W) + 2;
	localparam int PW     = DW + 13;
	localparam int SW     = PW + 1;
	localparam int LEN_W  = (STEP_BITS > 9) ? STEP_BITS : 9;

	logic [7:0]           lpwm_q, rpwm_q;
	logic [1:0]           route_q;
	logic                 drive_q;
	logic [STEP_BITS-1:0] step_q;

	logic                 action_s1;
	logic [RAMP_W-1:0]    ramp_s1;
	logic signed [DW-1:0] d_s2;
	logic signed [PW-1:0] lp_s3, rp_s3;

	logic signed [DIFF_W-1:0] diff;
	logic [DW-1:0]            dsh, rampx, d_d;
	logic [SW-1:0]            lsum, rsum;
	logic [7:0]               len_byte, lduty, rduty;
	logic [LEN_W-1:0]         len_w;
	logic [STEP_BITS-1:0]     step_inc, step_d;
	logic [7:0]               lpwm_d, rpwm_d;
	logic [1:0]               route_d;
	logic                     drive_d;

	// Floor of a Q.16 value, clamped to 0..255
	function automatic logic [7:0] to_duty(input logic [SW-1:0] q);
		logic [7:0] v;
		if (q[SW-1]) begin
			v = 8'd0;
		end else if (|q[SW-2:24]) begin
			v = 8'hFF;
		end else begin
			v = q[23:16];
		end
		return v;
	endfunction

	// Error term: (L - R + offset) << 8, minus/plus the ramp by route
	assign diff = $signed({2'b00, left_count}) - $signed({2'b00, right_count})
		+ $signed({{(DIFF_W-8){cfg.steady_offset[7]}}, cfg.steady_offset});
	assign dsh   = {{(DW-DIFF_W-8){diff[DIFF_W-1]}}, diff, 8'h00};
	assign rampx = {{(DW-RAMP_W){1'b0}}, ramp_s1};

	always_comb begin
		case (route_q)
			ROUTE_LEFT:  d_d = dsh - rampx;
			ROUTE_RIGHT: d_d = dsh + rampx;
			default:     d_d = dsh;
		endcase
	end

	// Base in Q.16 against the gain products
	assign lsum = {{(SW-24){1'b0}}, cfg.left_base, 8'h00} - {lp_s3[PW-1], lp_s3};
	assign rsum = {{(SW-24){1'b0}}, cfg.right_base, 8'h00} + {rp_s3[PW-1], rp_s3};
	assign lduty = to_duty(lsum);
	assign rduty = to_duty(rsum);

	// Run length of the current route, zero byte means 256
	assign len_byte = cfg.run_lengths[route_q*8 +: 8];
	assign len_w    = LEN_W'({(len_byte == 8'd0), len_byte});
	assign step_inc = step_q + STEP_BITS'(1);

	// Next controller state
	always_comb begin
		lpwm_d  = lpwm_q;
		rpwm_d  = rpwm_q;
		route_d = route_q;
		drive_d = drive_q;
		step_d  = step_q;
		if (!drive_q) begin
			route_d = route_q + 2'd1;
			drive_d = 1'b1;
			step_d  = '0;
		end else if (action_s1) begin
			if (step_q < STEP_BITS'(KICK_STEPS)) begin
				lpwm_d = cfg.jolt_pwm[7:0];
				rpwm_d = cfg.jolt_pwm[15:8];
			end else begin
				lpwm_d = lduty;
				rpwm_d = rduty;
			end
			step_d = step_inc;
			if (step_inc == len_w[STEP_BITS-1:0]) begin
				lpwm_d  = 8'd0;
				rpwm_d  = 8'd0;
				drive_d = 1'b0;
			end
		end
	end

	// Feedback pipeline
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			action_s1 <= action;
			ramp_s1   <= {{STEP_BITS{1'b0}}, cfg.turn_slope} * RAMP_W'(step_q);
		end
		if (ctl.diff) begin
			d_s2 <= $signed(d_d);
		end
		if (ctl.mult) begin
			lp_s3 <= $signed({1'b0, cfg.left_gain}) * d_s2;
			rp_s3 <= $signed({1'b0, cfg.right_gain}) * d_s2;
		end
	end

	// Drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpwm_q  <= '0;
			rpwm_q  <= '0;
			route_q <= ROUTE_FAR;
			drive_q <= 1'b1;
			step_q  <= '0;
		end else if (ctl.fin) begin
			lpwm_q  <= lpwm_d;
			rpwm_q  <= rpwm_d;
			route_q <= route_d;
			drive_q <= drive_d;
			step_q  <= step_d;
		end
	end

	assign nxt.left_pwm  = lpwm_d;
	assign nxt.right_pwm = rpwm_d;
	assign nxt.route     = route_d;
	assign nxt.driving   = drive_d;
	assign listen        = !drive_q;

endmodule

// ===== src/differential_drive_turn_controller_top.sv =====
// Each accepted item beat passes the wheel-lane divide-by-ten (reciprocal
// multiply, then correction) and the three-stage error/gain-multiply/clamp
// chain; a new item is stalled until the current one has finished that chain.
// The result register lets the next item enter while a result waits.
// Reset (arst_n, async): registers to defaults, filters and counts zero,
// drive state on the far route with both duties zero.
`timescale 1ns / 1ps

module differential_drive_turn_controller_top import ddtc_pkg::*; #(
	parameter int STEP_BITS = STEP_BITS_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg_q;
	logic [4:0] seq_q;
	logic       res_valid_q;
	result_t    res_q;

	logic       accept, fin, hold, wr, listen;
	logic [2:0] reg_idx;
	lane_ctl_t  lane_ctl;
	ctrl_ctl_t  ctrl_ctl;
	ctrl_stat_t nxt;
	logic [COUNT_BITS-1:0] left_count, right_count;

	// Handshakes
	assign item_stall = |seq_q;
	assign accept     = item_valid && !item_stall;
	assign hold       = seq_q[4] && res_valid_q && result_stall;
	assign fin        = seq_q[4] && !hold;

	// Phase sequencer, one-hot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (accept) begin
			seq_q <= 5'b00001;
		end else if (!hold) begin
			seq_q <= seq_q << 1;
		end
	end

	assign lane_ctl.load   = accept;
	assign lane_ctl.quot   = seq_q[0];
	assign lane_ctl.commit = seq_q[1];
	assign lane_ctl.clear  = listen;

	assign ctrl_ctl.load = accept;
	assign ctrl_ctl.diff = seq_q[2];
	assign ctrl_ctl.mult = seq_q[3];
	assign ctrl_ctl.fin  = fin;

	// Wheel lanes
	ddtc_wheel u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (item.left_sample),
		.count  (left_count)
	);

	ddtc_wheel u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (item.right_sample),
		.count  (right_count)
	);

	// Merge and feedback
	ddtc_ctrl #(
		.STEP_BITS (STEP_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctrl_ctl),
		.cfg         (cfg_q),
		.action      (item.action),
		.left_count  (left_count),
		.right_count (right_count),
		.nxt         (nxt),
		.listen      (listen)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.left_pwm    <= nxt.left_pwm;
			res_q.right_pwm   <= nxt.right_pwm;
			res_q.route       <= nxt.route;
			res_q.driving     <= nxt.driving;
			res_q.left_count  <= left_count;
			res_q.right_count <= right_count;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Register file
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_base     <= RST_LEFT_BASE;
			cfg_q.left_gain     <= RST_LEFT_GAIN;
			cfg_q.right_base    <= RST_RIGHT_BASE;
			cfg_q.right_gain    <= RST_RIGHT_GAIN;
			cfg_q.turn_slope    <= RST_TURN_SLOPE;
			cfg_q.steady_offset <= RST_STEADY_OFFSET;
			cfg_q.jolt_pwm      <= RST_JOLT_PWM;
			cfg_q.run_lengths   <= RST_RUN_LENGTHS;
		end else if (wr) begin
			case (reg_idx)
				REG_LEFT_BASE:     cfg_q.left_base     <= pwdata[15:0];
				REG_LEFT_GAIN:     cfg_q.left_gain     <= pwdata[11:0];
				REG_RIGHT_BASE:    cfg_q.right_base    <= pwdata[15:0];
				REG_RIGHT_GAIN:    cfg_q.right_gain    <= pwdata[11:0];
				REG_TURN_SLOPE:    cfg_q.turn_slope    <= pwdata[11:0];
				REG_STEADY_OFFSET: cfg_q.steady_offset <= pwdata[7:0];
				REG_JOLT_PWM:      cfg_q.jolt_pwm      <= pwdata[15:0];
				REG_RUN_LENGTHS:   cfg_q.run_lengths   <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_LEFT_BASE:     prdata = CFG_DATA_W'(cfg_q.left_base);
			REG_LEFT_GAIN:     prdata = CFG_DATA_W'(cfg_q.left_gain);
			REG_RIGHT_BASE:    prdata = CFG_DATA_W'(cfg_q.right_base);
			REG_RIGHT_GAIN:    prdata = CFG_DATA_W'(cfg_q.right_gain);
			REG_TURN_SLOPE:    prdata = CFG_DATA_W'(cfg_q.turn_slope);
			REG_STEADY_OFFSET: prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_q.steady_offset};
			REG_JOLT_PWM:      prdata = CFG_DATA_W'(cfg_q.jolt_pwm);
			REG_RUN_LENGTHS:   prdata = cfg_q.run_lengths;
			default:           prdata = '0;
		endcase
	end

`ifndef SYNTHESIS
	// Sequencer runs one phase at a time
	a_seq_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(seq_q))
		else $error("sequencer has more than one phase active");

	// A result beat appears only after a finalize phase
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(fin))
		else $error("result beat without finalize");

	// In listen state both duties are off
	a_listen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.driving) |->
			(result.left_pwm == 8'd0 && result.right_pwm == 8'd0))
		else $error("nonzero duty in listen state");

	// An accepted item starts the lanes on the next cycle
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (seq_q[0] && item_stall))
		else $error("accepted item did not start the sequencer");
`endif

endmodule

// ===== tb/differential_drive_turn_controller_top_tb.sv =====
// Testbench for differential_drive_turn_controller_top: random and directed encoder beats,
// register phases over the APB-style port, result beats checked against a local predictor.
// Depends on ddtc_pkg and the controller RTL.
`timescale 1ns / 1ps

// Predicts each result beat from the accepted item beats and checks the DUT against it
class drive_scoreboard;
	localparam int THR_LOW  = ((1 << ddtc_pkg::SAMPLE_BITS) * 2) / 10;
	localparam int THR_HIGH = ((1 << ddtc_pkg::SAMPLE_BITS) * 8) / 10;

	ddtc_pkg::cfg_t regs;
	logic [ddtc_pkg::SAMPLE_BITS-1:0] l_avg, r_avg;
	logic l_lvl, r_lvl;
	logic [ddtc_pkg::COUNT_BITS-1:0] l_cnt, r_cnt;
	logic [7:0] step;
	logic active;
	logic [1:0] route;
	logic [7:0] l_duty, r_duty;
	ddtc_pkg::result_t status_due[$];
	int errors;

	function new();
		regs.left_base     = ddtc_pkg::RST_LEFT_BASE;
		regs.left_gain     = ddtc_pkg::RST_LEFT_GAIN;
		regs.right_base    = ddtc_pkg::RST_RIGHT_BASE;
		regs.right_gain    = ddtc_pkg::RST_RIGHT_GAIN;
		regs.turn_slope    = ddtc_pkg::RST_TURN_SLOPE;
		regs.steady_offset = ddtc_pkg::RST_STEADY_OFFSET;
		regs.jolt_pwm      = ddtc_pkg::RST_JOLT_PWM;
		regs.run_lengths   = ddtc_pkg::RST_RUN_LENGTHS;
		l_avg = '0;
		r_avg = '0;
		l_lvl = 1'b0;
		r_lvl = 1'b0;
		l_cnt = '0;
		r_cnt = '0;
		step = '0;
		active = 1'b1;
		route = ddtc_pkg::ROUTE_FAR;
		l_duty = '0;
		r_duty = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			ddtc_pkg::REG_LEFT_BASE:     regs.left_base = v[15:0];
			ddtc_pkg::REG_LEFT_GAIN:     regs.left_gain = v[11:0];
			ddtc_pkg::REG_RIGHT_BASE:    regs.right_base = v[15:0];
			ddtc_pkg::REG_RIGHT_GAIN:    regs.right_gain = v[11:0];
			ddtc_pkg::REG_TURN_SLOPE:    regs.turn_slope = v[11:0];
			ddtc_pkg::REG_STEADY_OFFSET: regs.steady_offset = v[7:0];
			ddtc_pkg::REG_JOLT_PWM:      regs.jolt_pwm = v[15:0];
			ddtc_pkg::REG_RUN_LENGTHS:   regs.run_lengths = v;
			default: ;
		endcase
	endfunction

	// Running average and hysteresis for one wheel
	function void track_wheel(input logic [ddtc_pkg::SAMPLE_BITS-1:0] s,
			inout logic [ddtc_pkg::SAMPLE_BITS-1:0] avg, inout logic lvl,
			inout logic [ddtc_pkg::COUNT_BITS-1:0] cnt);
		int a;
		a = (3 * int'(avg) + 7 * int'(s)) / 10;
		avg = a[ddtc_pkg::SAMPLE_BITS-1:0];
		if ((!lvl && a > THR_HIGH) || (lvl && a < THR_LOW)) begin
			cnt = cnt + 1'b1;
			lvl = !lvl;
		end
	endfunction

	// Q.16 duty: floor, then clamp to 0..255
	function logic [7:0] to_duty(longint q);
		longint v;
		if (q < 0)
			return 8'd0;
		v = q / 65536;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function ddtc_pkg::result_t next_status(ddtc_pkg::item_t it);
		ddtc_pkg::result_t r;
		longint off, d, ramp;
		logic [7:0] nxt;
		track_wheel(it.left_sample, l_avg, l_lvl, l_cnt);
		track_wheel(it.right_sample, r_avg, r_lvl, r_cnt);
		if (!active) begin
			// listen: any beat moves to the next route and restarts the run
			route = route + 2'd1;
			active = 1'b1;
			step = '0;
			l_cnt = '0;
			r_cnt = '0;
		end else if (it.action) begin
			if (step < ddtc_pkg::KICK_STEPS) begin
				l_duty = regs.jolt_pwm[7:0];
				r_duty = regs.jolt_pwm[15:8];
			end else begin
				off = longint'($signed(regs.steady_offset));
				d = (longint'(l_cnt) - longint'(r_cnt) + off) * 256;
				ramp = longint'(regs.turn_slope) * longint'(step);
				if (route == ddtc_pkg::ROUTE_LEFT)
					d -= ramp;
				else if (route == ddtc_pkg::ROUTE_RIGHT)
					d += ramp;
				l_duty = to_duty(longint'(regs.left_base) * 256 - longint'(regs.left_gain) * d);
				r_duty = to_duty(longint'(regs.right_base) * 256 + longint'(regs.right_gain) * d);
			end
			nxt = step + 8'd1;
			step = nxt;
			// zero byte means 256 steps, which the 8-bit count reaches as 0
			if (nxt == regs.run_lengths[8*route +: 8]) begin
				l_duty = '0;
				r_duty = '0;
				active = 1'b0;
			end
		end
		r.left_pwm = l_duty;
		r.right_pwm = r_duty;
		r.route = route;
		r.driving = active;
		r.left_count = l_cnt;
		r.right_count = r_cnt;
		return r;
	endfunction

	function void note_item(ddtc_pkg::item_t it);
		status_due.push_back(next_status(it));
	endfunction

	function int pending();
		return status_due.size();
	endfunction

	task flag_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_result(ddtc_pkg::result_t got);
		ddtc_pkg::result_t want;
		if (status_due.size() == 0) begin
			flag_mismatch($sformatf("result beat with none expected: %h", got));
			return;
		end
		want = status_due.pop_front();
		if (got.left_pwm !== want.left_pwm)
			flag_mismatch($sformatf("left_pwm %0d, want %0d", got.left_pwm, want.left_pwm));
		if (got.right_pwm !== want.right_pwm)
			flag_mismatch($sformatf("right_pwm %0d, want %0d", got.right_pwm, want.right_pwm));
		if (got.route !== want.route)
			flag_mismatch($sformatf("route %0d, want %0d", got.route, want.route));
		if (got.driving !== want.driving)
			flag_mismatch($sformatf("driving %0b, want %0b", got.driving, want.driving));
		if (got.left_count !== want.left_count)
			flag_mismatch($sformatf("left_count %0d, want %0d", got.left_count,
				want.left_count));
		if (got.right_count !== want.right_count)
			flag_mismatch($sformatf("right_count %0d, want %0d", got.right_count,
				want.right_count));
	endtask
endclass

module differential_drive_turn_controller_top_tb;
	import ddtc_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int LONG_HOLD     = 120;
	localparam int SETTLE_CYCLES = 12;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	drive_scoreboard sb;
	int quiet_cycles = 0;
	bit hold_req = 1'b0;
	int burst_left;
	// encoder square-wave shaping
	bit l_high, r_high;
	int l_run, r_run;

	// {action, left_sample, right_sample}
	logic [24:0] directed_beats [20] = '{
		{1'b0, 12'h000, 12'h000}, {1'b1, 12'hFFF, 12'hFFF}, {1'b1, 12'hFFF, 12'hFFF},
		{1'b1, 12'hFFF, 12'h000}, {1'b1, 12'hFFF, 12'h000}, {1'b0, 12'h000, 12'hFFF},
		{1'b1, 12'h000, 12'hFFF}, {1'b1, 12'h000, 12'h000}, {1'b1, 12'h000, 12'h000},
		{1'b0, 12'hFFF, 12'hFFF}, {1'b1, 12'hFFF, 12'hFFF}, {1'b1, 12'hAAA, 12'h555},
		{1'b1, 12'h555, 12'hAAA}, {1'b1, 12'hCCC, 12'h333}, {1'b0, 12'h333, 12'hCCC},
		{1'b1, 12'h000, 12'hFFF}, {1'b1, 12'hFFF, 12'h000}, {1'b1, 12'h800, 12'h7FF},
		{1'b1, 12'h7FF, 12'h800}, {1'b0, 12'hFFF, 12'hFFF}
	};

	differential_drive_turn_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result checks and the no-progress counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (psel && penable && pwrite && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stall pattern in modes, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int tick;
		result_stall = 1'b0;
		mode = RX_OPEN;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (tick % 64 == 0)
					mode = rx_mode_t'($urandom_range(0, 3));
				tick++;
				case (mode)
					RX_OPEN:  result_stall <= 1'b0;
					RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: result_stall <= ($urandom_range(0, 9) < 6);
					default:  result_stall <= (tick % 5 < 2);
				endcase
			end
		end
	end

	// One item beat, with a random gap at the start of each burst
	task automatic offer(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_config(input logic [15:0] lb, input logic [11:0] lg,
			input logic [15:0] rb, input logic [11:0] rg, input logic [11:0] ts,
			input logic [7:0] so, input logic [15:0] jp, input logic [31:0] rl);
		write_reg(REG_LEFT_BASE, {16'd0, lb});
		write_reg(REG_LEFT_GAIN, {20'd0, lg});
		write_reg(REG_RIGHT_BASE, {16'd0, rb});
		write_reg(REG_RIGHT_GAIN, {20'd0, rg});
		write_reg(REG_TURN_SLOPE, {20'd0, ts});
		write_reg(REG_STEADY_OFFSET, {24'd0, so});
		write_reg(REG_JOLT_PWM, {16'd0, jp});
		write_reg(REG_RUN_LENGTHS, rl);
	endtask

	task automatic random_config();
		load_config(16'($urandom), 12'($urandom), 16'($urandom), 12'($urandom),
			12'($urandom), 8'($urandom),
			16'($urandom), {8'($urandom_range(3, 24)), 8'($urandom_range(3, 24)),
			8'($urandom_range(3, 24)), 8'($urandom_range(3, 24))});
	endtask

	function automatic logic [11:0] wheel_sample(input bit hi);
		return hi ? 12'($urandom_range(3400, 4095)) : 12'($urandom_range(0, 700));
	endfunction

	// Mostly square-wave encoder content that crosses both thresholds; some noise
	task automatic make_item(output item_t it);
		if ($urandom_range(0, 99) < 15) begin
			it.action = 1'($urandom_range(0, 1));
			it.left_sample = 12'($urandom_range(0, 4095));
			it.right_sample = 12'($urandom_range(0, 4095));
		end else begin
			if (l_run == 0) begin
				l_high = !l_high;
				l_run = $urandom_range(1, 5);
			end
			if (r_run == 0) begin
				r_high = !r_high;
				r_run = $urandom_range(1, 5);
			end
			l_run--;
			r_run--;
			it.action = ($urandom_range(0, 99) < 85);
			it.left_sample = wheel_sample(l_high);
			it.right_sample = wheel_sample(r_high);
		end
	endtask

	// Tick until the current run ends, so a new setting starts on a fresh run
	task automatic finish_route();
		item_t it;
		while (sb.active) begin
			make_item(it);
			it.action = 1'b1;
			offer(it);
		end
	endtask

	task automatic run_phase(input int n, input int hold_at);
		item_t it;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			make_item(it);
			offer(it);
		end
		finish_route();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		l_high = 1'b0;
		r_high = 1'b0;
		l_run = 0;
		r_run = 0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed beats at reset settings: sample extremes, ticks and plain samples
		for (int i = 0; i < 20; i++)
			offer(item_t'(directed_beats[i]));
		finish_route();
		drain();

		// top of every register range, short runs; long result hold-off inside
		load_config(16'hFFFF, 12'hFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 8'h7F, 16'hFFFF,
			32'h06050403);
		run_phase(150, 50);

		// bottom of the ranges except the right gain at top, every run a single jolt step
		load_config(16'h0000, 12'h000, 16'h0000, 12'hFFF, 12'h000, 8'h80, 16'h00FF,
			32'h01010101);
		run_phase(60, -1);

		// reset-like gains; the right route runs 256 steps so the step count wraps
		load_config(RST_LEFT_BASE, RST_LEFT_GAIN, RST_RIGHT_BASE, RST_RIGHT_GAIN,
			RST_TURN_SLOPE, RST_STEADY_OFFSET, RST_JOLT_PWM, 32'h00010101);
		run_phase(300, -1);

		repeat (3) begin
			random_config();
			run_phase(160, -1);
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
